### design/sorted_sequence_merger_core_assert.svh
// Assertion macros for the sequence merger core.
// Each macro expects clk and arst_n in scope.
`ifndef SORTED_SEQUENCE_MERGER_CORE_ASSERT_SVH
`define SORTED_SEQUENCE_MERGER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssm assertion failed");

// Next-cycle implication, held off during reset.
`define SSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssm assertion failed");

`endif

### design/ssm_pkg.sv
package ssm_pkg;

	localparam int VALUE_W      = 32;
	localparam int SEQ_ID_W     = 3;
	localparam int SSM_CAPACITY = 64;
	localparam int SSM_NUM_SEQS = 8;

	typedef enum logic {
		CMD_PUSH  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_UNSORTED = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic [SEQ_ID_W-1:0]        seq_id;
		logic signed [VALUE_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  value_out;
		status_t                    status;
		logic                       last;
	} res_t;

endpackage

### design/ssm_cmp.sv
module ssm_cmp (
	input  logic signed [ssm_pkg::VALUE_W-1:0] a,
	input  logic signed [ssm_pkg::VALUE_W-1:0] b,
	output logic                               lt
);
	import ssm_pkg::*;

	// Flip the sign bits so an unsigned compare gives signed order
	logic [VALUE_W-1:0] key_a;
	logic [VALUE_W-1:0] key_b;

	assign key_a = {~a[VALUE_W-1], a[VALUE_W-2:0]};
	assign key_b = {~b[VALUE_W-1], b[VALUE_W-2:0]};
	assign lt    = key_a < key_b;

endmodule

### design/sorted_sequence_merger_core.sv
// Merger of up to NUM_SEQS sorted sequences into one ascending run. Busy stays low
// during pushes, so pushes stream back to back; the order check of a push completes
// in the cycle after it. A flush beat raises busy: an error or empty flush gives a
// single result from the evaluation state, and a flush of n stored values runs n
// selection rounds, each a scan over all stored values through the single value-store
// read port feeding the one shared comparator.
// Results appear on result for one cycle each, marked by result_valid, and must be
// taken as they come: there is no back-pressure on the result side. After every flush
// the block is empty again and needs no clearing pass.
`include "sorted_sequence_merger_core_assert.svh"

module sorted_sequence_merger_core #(
	parameter int CAPACITY = ssm_pkg::SSM_CAPACITY,
	parameter int NUM_SEQS = ssm_pkg::SSM_NUM_SEQS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ssm_pkg::item_t item,
	output logic           result_valid,
	output ssm_pkg::res_t  result
);
	import ssm_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SEQ_W  = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
	localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
	localparam logic [6:0]       NSEQ_C = 7'(NUM_SEQS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_SCAN = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q;

	// Storage
	logic signed [VALUE_W-1:0] store_mem [CAPACITY];
	logic signed [VALUE_W-1:0] last_mem  [NUM_SEQS];
	logic [NUM_SEQS-1:0]       seen_q;
	logic [CNT_W-1:0]          count_q;
	logic                      unsorted_q;
	logic                      overflow_q;

	// Order-check stage
	logic                      pv_s1;
	logic                      pseen_s1;
	logic signed [VALUE_W-1:0] pval_s1;
	logic signed [VALUE_W-1:0] plast_s1;

	// Selection scan
	logic [CNT_W-1:0]          scan_q;
	logic [CNT_W-1:0]          emit_q;
	logic                      rd_vld_s1;
	logic [ADDR_W-1:0]         rd_idx_s1;
	logic signed [VALUE_W-1:0] rd_s1;
	logic signed [VALUE_W-1:0] best_q;
	logic [ADDR_W-1:0]         best_idx_q;
	logic                      best_vld_q;
	logic [CAPACITY-1:0]       taken_q;

	res_t                      res_q;
	logic                      res_vld_q;

	logic                      accept;
	logic                      push_ok;
	logic [6:0]                id_ext;
	logic [SEQ_W-1:0]          sidx;
	logic                      room;
	logic signed [VALUE_W-1:0] cmp_a;
	logic signed [VALUE_W-1:0] cmp_b;
	logic                      lt;
	logic                      take;
	logic                      scan_more;
	logic                      is_last;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign id_ext       = 7'(item.seq_id);
	assign sidx         = id_ext[SEQ_W-1:0];
	assign push_ok      = accept && (item.cmd == CMD_PUSH) && (id_ext < NSEQ_C);
	assign room         = count_q < CAP_C;
	assign scan_more    = scan_q < count_q;
	assign is_last      = (CNT_W'(emit_q + 1'b1) == count_q);
	assign result_valid = res_vld_q;
	assign result       = res_q;

	// Share the comparator between the order check and the selection scan
	assign cmp_a = pv_s1 ? pval_s1 : rd_s1;
	assign cmp_b = pv_s1 ? plast_s1 : best_q;

	ssm_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt)
	);

	assign take = rd_vld_s1 && !taken_q[rd_idx_s1] && (!best_vld_q || lt);

	// Memories and data path registers
	always_ff @(posedge clk) begin
		if (push_ok) begin
			last_mem[sidx] <= item.value;
			plast_s1       <= last_mem[sidx];
			pval_s1        <= item.value;
			if (room) begin
				store_mem[count_q[ADDR_W-1:0]] <= item.value;
			end
		end
		if (state_q == S_SCAN && scan_more) begin
			rd_s1     <= store_mem[scan_q[ADDR_W-1:0]];
			rd_idx_s1 <= scan_q[ADDR_W-1:0];
		end
		if (state_q == S_SCAN && take) begin
			best_q     <= rd_s1;
			best_idx_q <= rd_idx_s1;
		end
	end

	// Control: push bookkeeping, flush sequencer, result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			seen_q     <= '0;
			count_q    <= '0;
			unsorted_q <= 1'b0;
			overflow_q <= 1'b0;
			pv_s1      <= 1'b0;
			pseen_s1   <= 1'b0;
			scan_q     <= '0;
			emit_q     <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			taken_q    <= '0;
			res_q      <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			pv_s1     <= push_ok;

			// Finish the order check of the previous push
			if (pv_s1 && pseen_s1 && lt) begin
				unsorted_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (push_ok) begin
						pseen_s1     <= seen_q[sidx];
						seen_q[sidx] <= 1'b1;
						if (room) begin
							count_q <= CNT_W'(count_q + 1'b1);
						end else begin
							overflow_q <= 1'b1;
						end
					end
					if (accept && item.cmd == CMD_FLUSH) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_q.value_out <= '0;
					res_q.last      <= 1'b1;
					if (unsorted_q || overflow_q || count_q == '0) begin
						res_vld_q <= 1'b1;
						if (unsorted_q) begin
							res_q.status <= ST_UNSORTED;
						end else if (overflow_q) begin
							res_q.status <= ST_OVERFLOW;
						end else begin
							res_q.status <= ST_EMPTY;
						end
						seen_q     <= '0;
						count_q    <= '0;
						unsorted_q <= 1'b0;
						overflow_q <= 1'b0;
						state_q    <= S_IDLE;
					end else begin
						scan_q     <= '0;
						emit_q     <= '0;
						best_vld_q <= 1'b0;
						taken_q    <= '0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Issue one read a cycle, compare the beat that returns
					rd_vld_s1 <= scan_more;
					if (scan_more) begin
						scan_q <= CNT_W'(scan_q + 1'b1);
					end
					if (take) begin
						best_vld_q <= 1'b1;
					end
					if (!scan_more && !rd_vld_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					res_vld_q            <= 1'b1;
					res_q.value_out      <= best_q;
					res_q.status         <= ST_DATA;
					res_q.last           <= is_last;
					taken_q[best_idx_q]  <= 1'b1;
					emit_q               <= CNT_W'(emit_q + 1'b1);
					scan_q               <= '0;
					best_vld_q           <= 1'b0;
					if (is_last) begin
						seen_q     <= '0;
						count_q    <= '0;
						unsorted_q <= 1'b0;
						overflow_q <= 1'b0;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Error and empty results always close the flush
	`SSM_ASSERT_NOW(a_err_is_last, res_vld_q && res_q.status != ST_DATA, res_q.last)
	// The last result leaves the block cleared and idle
	`SSM_ASSERT_NOW(a_last_clears, res_vld_q && res_q.last,
		state_q == S_IDLE && count_q == '0 && !overflow_q)
	// Stored count never passes capacity
	`SSM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_C)
	// A scan read only returns while scanning
	`SSM_ASSERT_NEXT(a_scan_read, state_q == S_SCAN && scan_more, rd_vld_s1 && state_q == S_SCAN)

endmodule
